>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock and active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/rdi_pkg.sv
// ---------------------------------------------------------------------------
// rdi_pkg
// Types, widths, register indexes and the arctangent table for the ray/disk
// intersection block.
// ---------------------------------------------------------------------------
`default_nettype none

package rdi_pkg;

    localparam int COORD_W    = 32;
    localparam int AXIS_W     = 16;
    localparam int AXES_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int S_TDATA_W  = 256;
    localparam int M_TDATA_W  = 64;

    localparam int DEFAULT_CORDIC_STEPS = 16;
    localparam int DEFAULT_QUEUE_DEPTH  = 4;
    localparam int ATAN_ENTRIES         = 24;

    // t divider: numerator/denominator width, magnitude width, quotient bits
    localparam int NUM_W     = 50;
    localparam int MAG_W     = 48;
    localparam int FRAC_BITS = 16;
    localparam int Q_BITS    = 33;
    localparam int LOW_BITS  = Q_BITS - FRAC_BITS;

    // v divider quotient bits (quotient can reach 65536)
    localparam int V_QUO_W = 17;
    localparam int W_CLAMP = 33554432;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NORMAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_AXIS_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_AXIS_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET    = 3'd7;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t [2:0] org;
        coord_t [2:0] dir;
        coord_t       t_min;
        coord_t       t_limit;
    } ray_t;

    typedef struct packed {
        ray_t                     ray;
        logic                     par;
        logic signed [NUM_W-1:0]  num;
        logic signed [NUM_W-1:0]  den;
    } front_item_t;

    typedef struct packed {
        logic [AXES_W-1:0]  normal;
        logic [AXES_W-1:0]  axis1;
        logic [AXES_W-1:0]  axis2;
        coord_t [2:0]       center;
        logic [COORD_W-1:0] radius_sq;
        coord_t             offset;
    } cfg_t;

    function automatic logic signed [AXIS_W-1:0] lane(input logic [AXES_W-1:0] p,
                                                      input int k);
        return $signed(p[AXIS_W*k +: AXIS_W]);
    endfunction

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input int i);
        logic [29:0] a;
        case (i)
            0:  a = 30'd536870912;
            1:  a = 30'd316933406;
            2:  a = 30'd167458907;
            3:  a = 30'd85004756;
            4:  a = 30'd42667331;
            5:  a = 30'd21354465;
            6:  a = 30'd10679838;
            7:  a = 30'd5340245;
            8:  a = 30'd2670163;
            9:  a = 30'd1335087;
            10: a = 30'd667544;
            11: a = 30'd333772;
            12: a = 30'd166886;
            13: a = 30'd83443;
            14: a = 30'd41722;
            15: a = 30'd20861;
            16: a = 30'd10430;
            17: a = 30'd5215;
            18: a = 30'd2608;
            19: a = 30'd1304;
            20: a = 30'd652;
            21: a = 30'd326;
            22: a = 30'd163;
            23: a = 30'd81;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> design/rdi_front.sv
// ---------------------------------------------------------------------------
// rdi_front
// Accepts rays, forms the plane numerator and denominator, flags parallel
// rays and pushes the classified item into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module rdi_front #(
    parameter int QUEUE_DEPTH = rdi_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rdi_pkg::S_TDATA_W-1:0]     s_tdata,
    input  rdi_pkg::cfg_t                     cfg,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_count,
    output logic                              push_valid,
    output rdi_pkg::front_item_t              push_item
);
    import rdi_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic                      f1_valid_reg;
    ray_t                      f1_ray_reg;
    logic signed [47:0]        pd_reg [3];
    logic signed [47:0]        po_reg [3];
    logic signed [47:0]        pd_next [3];
    logic signed [47:0]        po_next [3];
    ray_t                      ray_in;
    logic                      push_valid_reg;
    front_item_t               push_item_reg;
    front_item_t               item_next;
    logic [CNT_W:0]            used;
    logic                      take;

    // slots already promised: queue fill plus both front stages
    assign used     = {1'b0, q_count} + (CNT_W+1)'(f1_valid_reg) + (CNT_W+1)'(push_valid_reg);
    assign s_tready = used < (CNT_W+1)'(QUEUE_DEPTH);
    assign take     = s_tvalid && s_tready;

    always_comb begin
        ray_in.org[0]  = s_tdata[31:0];
        ray_in.org[1]  = s_tdata[63:32];
        ray_in.org[2]  = s_tdata[95:64];
        ray_in.dir[0]  = s_tdata[127:96];
        ray_in.dir[1]  = s_tdata[159:128];
        ray_in.dir[2]  = s_tdata[191:160];
        ray_in.t_min   = s_tdata[223:192];
        ray_in.t_limit = s_tdata[255:224];
        for (int k = 0; k < 3; k++) begin
            pd_next[k] = lane(cfg.normal, k) * $signed(ray_in.dir[k]);
            po_next[k] = lane(cfg.normal, k) * $signed(ray_in.org[k]);
        end
    end

    always_comb begin
        item_next.ray = f1_ray_reg;
        item_next.den = NUM_W'(pd_reg[0]) + NUM_W'(pd_reg[1]) + NUM_W'(pd_reg[2]);
        item_next.num = -(NUM_W'(cfg.offset) <<< 14)
                        - (NUM_W'(po_reg[0]) + NUM_W'(po_reg[1]) + NUM_W'(po_reg[2]));
        item_next.par = (item_next.den == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg   <= 1'b0;
            push_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg   <= take;
            push_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f1_ray_reg    <= ray_in;
        pd_reg        <= pd_next;
        po_reg        <= po_next;
        push_item_reg <= item_next;
    end

    assign push_valid = push_valid_reg;
    assign push_item  = push_item_reg;

endmodule

`default_nettype wire

>>> design/rdi_queue.sv
// ---------------------------------------------------------------------------
// rdi_queue
// Short FIFO between front and back; the front reserves space ahead.
// ---------------------------------------------------------------------------
`default_nettype none

module rdi_queue #(
    parameter int QUEUE_DEPTH = rdi_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  rdi_pkg::front_item_t              push_item,
    input  logic                              pop,
    output logic                              q_valid,
    output rdi_pkg::front_item_t              q_item,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_count
);
    import rdi_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    front_item_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];
    assign q_count = count_reg;

endmodule

`default_nettype wire

>>> design/rdi_back.sv
// ---------------------------------------------------------------------------
// rdi_back
// Pipelined t divider, hit point, radius test, v divider and CORDIC angle.
// All stages advance together whenever the output register can move.
// ---------------------------------------------------------------------------
`default_nettype none

module rdi_back #(
    parameter int CORDIC_STEPS = rdi_pkg::DEFAULT_CORDIC_STEPS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rdi_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  rdi_pkg::front_item_t          q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rdi_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]                    m_tuser
);
    import rdi_pkg::*;

    localparam int ROT_STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int SH_STEPS  = (ROT_STEPS > V_QUO_W) ? ROT_STEPS : V_QUO_W;
    localparam int CW        = 48;
    localparam int AW        = 34;

    typedef struct packed {
        ray_t               ray;
        logic               par;
        logic               neg;
        logic               sat;
        logic [Q_BITS-1:0]  xlow;
        logic [MAG_W-1:0]   ad;
        logic [MAG_W:0]     rem;
        logic [Q_BITS-1:0]  quo;
    } div_stage_t;

    typedef struct packed {
        ray_t   ray;
        coord_t t;
        logic   miss;
    } t_stage_t;

    typedef struct packed {
        coord_t            t;
        logic              miss;
        logic [2:0][32:0]  diff;
        logic [2:0][63:0]  prod;
    } m1_stage_t;

    typedef struct packed {
        coord_t            t;
        logic              miss;
        logic [2:0][26:0]  w;
    } m2_stage_t;

    typedef struct packed {
        coord_t            t;
        logic              miss;
        logic [2:0][53:0]  sq;
        logic [2:0][42:0]  p1;
        logic [2:0][42:0]  p2;
    } m3_stage_t;

    typedef struct packed {
        coord_t             t;
        logic               miss;
        logic [51:0]        dist2;
        logic signed [44:0] px;
        logic signed [44:0] py;
    } m4_stage_t;

    typedef struct packed {
        coord_t               t;
        logic                 miss;
        logic                 zero;
        logic [V_QUO_W-1:0]   vlow;
        logic [32:0]          vrem;
        logic [V_QUO_W-1:0]   vquo;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
    } rot_stage_t;

    logic        en;
    div_stage_t  d_reg   [Q_BITS+1];
    div_stage_t  d_next  [Q_BITS+1];
    logic        dv_reg  [Q_BITS+1];
    t_stage_t    t_reg, t_next;
    logic        tv_reg;
    m1_stage_t   m1_reg, m1_next;
    m2_stage_t   m2_reg, m2_next;
    m3_stage_t   m3_reg, m3_next;
    m4_stage_t   m4_reg, m4_next;
    logic        m1v_reg, m2v_reg, m3v_reg, m4v_reg;
    rot_stage_t  s_reg   [SH_STEPS+1];
    rot_stage_t  s_next  [SH_STEPS+1];
    logic        sv_reg  [SH_STEPS+1];
    logic        out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 out_hit_reg, out_hit_next;

    assign en    = !out_valid_reg || m_tready;
    assign q_pop = en && q_valid;

    // ---- t = num / den, restoring division, one quotient bit per stage ----
    always_comb begin
        logic [NUM_W-1:0] an_full, ad_full;
        logic [MAG_W-1:0] an;
        logic [MAG_W:0]   sh;
        an_full = q_item.num[NUM_W-1] ? NUM_W'(-q_item.num) : q_item.num;
        ad_full = q_item.den[NUM_W-1] ? NUM_W'(-q_item.den) : q_item.den;
        an      = an_full[MAG_W-1:0];
        d_next[0].ray  = q_item.ray;
        d_next[0].par  = q_item.par;
        d_next[0].neg  = q_item.num[NUM_W-1] != q_item.den[NUM_W-1];
        d_next[0].ad   = ad_full[MAG_W-1:0];
        d_next[0].sat  = {{LOW_BITS{1'b0}}, an} >= {ad_full[MAG_W-1:0], {LOW_BITS{1'b0}}};
        d_next[0].xlow = {an[LOW_BITS-1:0], {FRAC_BITS{1'b0}}};
        d_next[0].rem  = (MAG_W+1)'(an >> LOW_BITS);
        d_next[0].quo  = '0;
        for (int j = 0; j < Q_BITS; j++) begin
            d_next[j+1] = d_reg[j];
            sh = {d_reg[j].rem[MAG_W-1:0], d_reg[j].xlow[Q_BITS-1-j]};
            if (sh >= {1'b0, d_reg[j].ad}) begin
                d_next[j+1].rem = sh - {1'b0, d_reg[j].ad};
                d_next[j+1].quo = {d_reg[j].quo[Q_BITS-2:0], 1'b1};
            end else begin
                d_next[j+1].rem = sh;
                d_next[j+1].quo = {d_reg[j].quo[Q_BITS-2:0], 1'b0};
            end
        end
    end

    // ---- saturate t and test the interval ----
    always_comb begin
        logic [Q_BITS-1:0] mag;
        div_stage_t        dl;
        dl = d_reg[Q_BITS];
        mag = (dl.sat || dl.quo[Q_BITS-1]) ? {1'b1, {(Q_BITS-1){1'b0}}} : dl.quo;
        if (dl.neg)
            t_next.t = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - mag);
        else
            t_next.t = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        t_next.ray  = dl.ray;
        t_next.miss = dl.par || (t_next.t < dl.ray.t_min) || (t_next.t > dl.ray.t_limit);
    end

    // ---- hit point offset w and its products ----
    always_comb begin
        logic signed [65:0] a;
        logic signed [65:0] af;
        logic signed [53:0] sqv;
        logic signed [42:0] pa, pb;
        logic signed [63:0] pr;
        m1_next.t    = t_reg.t;
        m1_next.miss = t_reg.miss;
        for (int k = 0; k < 3; k++) begin
            m1_next.diff[k] = 33'($signed(t_reg.ray.org[k])) - 33'($signed(cfg.center[k]));
            pr              = $signed(t_reg.t) * $signed(t_reg.ray.dir[k]);
            m1_next.prod[k] = pr;
        end
        m2_next.t    = m1_reg.t;
        m2_next.miss = m1_reg.miss;
        for (int k = 0; k < 3; k++) begin
            a  = (66'($signed(m1_reg.diff[k])) <<< 16) + 66'($signed(m1_reg.prod[k]));
            af = a >>> 16;
            if (af > W_CLAMP)
                m2_next.w[k] = 27'(W_CLAMP);
            else if (af < -W_CLAMP)
                m2_next.w[k] = 27'(-W_CLAMP);
            else
                m2_next.w[k] = af[26:0];
        end
        m3_next.t    = m2_reg.t;
        m3_next.miss = m2_reg.miss;
        for (int k = 0; k < 3; k++) begin
            sqv = $signed(m2_reg.w[k]) * $signed(m2_reg.w[k]);
            pa  = lane(cfg.axis1, k) * $signed(m2_reg.w[k]);
            pb  = lane(cfg.axis2, k) * $signed(m2_reg.w[k]);
            m3_next.sq[k] = sqv;
            m3_next.p1[k] = pa;
            m3_next.p2[k] = pb;
        end
        m4_next.t     = m3_reg.t;
        m4_next.dist2 = 52'(m3_reg.sq[0]) + 52'(m3_reg.sq[1]) + 52'(m3_reg.sq[2]);
        m4_next.px    = 45'($signed(m3_reg.p1[0])) + 45'($signed(m3_reg.p1[1]))
                        + 45'($signed(m3_reg.p1[2]));
        m4_next.py    = 45'($signed(m3_reg.p2[0])) + 45'($signed(m3_reg.p2[1]))
                        + 45'($signed(m3_reg.p2[2]));
        m4_next.miss  = m3_reg.miss || (m4_next.dist2 > {cfg.radius_sq, 16'h0000});
    end

    // ---- v division and CORDIC share one stage chain ----
    always_comb begin
        logic signed [CW-1:0] xe, ye;
        logic [32:0]          vs;
        s_next[0].t    = m4_reg.t;
        s_next[0].miss = m4_reg.miss;
        s_next[0].zero = (m4_reg.px == '0) && (m4_reg.py == '0);
        s_next[0].vlow = m4_reg.dist2[V_QUO_W-1:0];
        s_next[0].vrem = 33'(m4_reg.dist2 >> V_QUO_W);
        s_next[0].vquo = '0;
        xe = CW'(m4_reg.px);
        ye = CW'(m4_reg.py);
        if (m4_reg.px < 0) begin
            s_next[0].x   = -xe;
            s_next[0].y   = -ye;
            s_next[0].ang = (m4_reg.py >= 0) ? 34'sh0_8000_0000 : -34'sh0_8000_0000;
        end else begin
            s_next[0].x   = xe;
            s_next[0].y   = ye;
            s_next[0].ang = '0;
        end
        for (int j = 0; j < SH_STEPS; j++) begin
            s_next[j+1] = s_reg[j];
            if (j < V_QUO_W) begin
                vs = {s_reg[j].vrem[31:0], s_reg[j].vlow[V_QUO_W-1-j]};
                if (vs >= {1'b0, cfg.radius_sq}) begin
                    s_next[j+1].vrem = vs - {1'b0, cfg.radius_sq};
                    s_next[j+1].vquo = {s_reg[j].vquo[V_QUO_W-2:0], 1'b1};
                end else begin
                    s_next[j+1].vrem = vs;
                    s_next[j+1].vquo = {s_reg[j].vquo[V_QUO_W-2:0], 1'b0};
                end
            end
            if (j < ROT_STEPS) begin
                if (s_reg[j].y > 0) begin
                    s_next[j+1].x   = s_reg[j].x + (s_reg[j].y >>> j);
                    s_next[j+1].y   = s_reg[j].y - (s_reg[j].x >>> j);
                    s_next[j+1].ang = s_reg[j].ang + AW'(atan_turn(j));
                end else begin
                    s_next[j+1].x   = s_reg[j].x - (s_reg[j].y >>> j);
                    s_next[j+1].y   = s_reg[j].y + (s_reg[j].x >>> j);
                    s_next[j+1].ang = s_reg[j].ang - AW'(atan_turn(j));
                end
            end
        end
    end

    // ---- final scaling and miss masking ----
    always_comb begin
        rot_stage_t           sl;
        logic signed [AW-1:0] sa;
        logic signed [AW-1:0] uf;
        logic [15:0]          u;
        logic [15:0]          v;
        sl = s_reg[SH_STEPS];
        sa = sl.ang + 34'sh0_8000_0000;
        uf = sa >>> 16;
        if (sl.zero)
            u = 16'h8000;
        else if (uf < 0)
            u = 16'h0000;
        else if (uf > 65535)
            u = 16'hFFFF;
        else
            u = uf[15:0];
        if (cfg.radius_sq == '0)
            v = 16'h0000;
        else if (sl.vquo > 17'd65535)
            v = 16'hFFFF;
        else
            v = sl.vquo[15:0];
        if (sl.miss) begin
            out_data_next = '0;
            out_hit_next  = 1'b0;
        end else begin
            out_data_next = {v, u, sl.t};
            out_hit_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= Q_BITS; j++)
                dv_reg[j] <= 1'b0;
            tv_reg  <= 1'b0;
            m1v_reg <= 1'b0;
            m2v_reg <= 1'b0;
            m3v_reg <= 1'b0;
            m4v_reg <= 1'b0;
            for (int j = 0; j <= SH_STEPS; j++)
                sv_reg[j] <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= q_valid;
            for (int j = 0; j < Q_BITS; j++)
                dv_reg[j+1] <= dv_reg[j];
            tv_reg  <= dv_reg[Q_BITS];
            m1v_reg <= tv_reg;
            m2v_reg <= m1v_reg;
            m3v_reg <= m2v_reg;
            m4v_reg <= m3v_reg;
            sv_reg[0] <= m4v_reg;
            for (int j = 0; j < SH_STEPS; j++)
                sv_reg[j+1] <= sv_reg[j];
            out_valid_reg <= sv_reg[SH_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j <= Q_BITS; j++)
                d_reg[j] <= d_next[j];
            t_reg  <= t_next;
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            m3_reg <= m3_next;
            m4_reg <= m4_next;
            for (int j = 0; j <= SH_STEPS; j++)
                s_reg[j] <= s_next[j];
            out_data_reg <= out_data_next;
            out_hit_reg  <= out_hit_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

endmodule

`default_nettype wire

>>> design/ray_disk_intersect_uv.sv
// ---------------------------------------------------------------------------
// ray_disk_intersect_uv
// Ray against configured disk: hit flag, t and polar texture coordinates.
// ---------------------------------------------------------------------------
// Takes one ray per clock while s_tready is high and returns one result
// per ray, in order. The front forms N.dir and the plane numerator in two
// stages and reserves a slot in a short queue; the back runs a 33-stage
// restoring divider for t, four stages for the hit offset, its squares
// and axis projections, then a shared chain of max(17, min(CORDIC_STEPS,
// ATAN_ENTRIES)) stages that carries the v divider and the CORDIC angle
// side by side. m_tready stalls the whole back at once; the queue keeps
// s_tready high during a short stall, and it falls only once the queue
// plus the two front stages are spoken for. A miss (parallel ray, t
// outside [t_min, t_limit] or beyond the radius) returns all-zero data
// with the hit flag low. The user must write configuration only while no
// ray is in flight; the block itself does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

module ray_disk_intersect_uv #(
    parameter int CORDIC_STEPS = rdi_pkg::DEFAULT_CORDIC_STEPS,
    parameter int QUEUE_DEPTH  = rdi_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata, low bit up: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // t_min, t_limit (32 bits each)
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rdi_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata, low bit up: hit_t (32), tex_u (16), tex_v (16)
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rdi_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: hit
    output logic [0:0]                      m_tuser,
    input  logic                            cfg_we,
    input  logic [rdi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rdi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rdi_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    cfg_t               cfg_reg;
    logic               push_valid;
    front_item_t        push_item;
    logic               q_pop;
    logic               q_valid;
    front_item_t        q_item;
    logic [CNT_W-1:0]   q_count;

    // register file; plain writes, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PLANE_NORMAL:    cfg_reg.normal    <= cfg_wdata;
                REG_TEX_AXIS_FIRST:  cfg_reg.axis1     <= cfg_wdata;
                REG_TEX_AXIS_SECOND: cfg_reg.axis2     <= cfg_wdata;
                REG_CENTER_X:        cfg_reg.center[0] <= cfg_wdata[31:0];
                REG_CENTER_Y:        cfg_reg.center[1] <= cfg_wdata[31:0];
                REG_CENTER_Z:        cfg_reg.center[2] <= cfg_wdata[31:0];
                REG_RADIUS_SQ:       cfg_reg.radius_sq <= cfg_wdata[31:0];
                REG_PLANE_OFFSET:    cfg_reg.offset    <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // front: plane terms and parallel check
    rdi_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (cfg_reg),
        .q_count    (q_count),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // decoupling queue
    rdi_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_count   (q_count)
    );

    // back: divide, hit point, radius test, texture coordinates
    rdi_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> design/rdi_checker.sv
// ---------------------------------------------------------------------------
// rdi_checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rdi_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [rdi_pkg::S_TDATA_W-1:0]   s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rdi_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic [0:0]                      m_tuser,
    input wire logic                            cfg_we,
    input wire logic [rdi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input wire logic [rdi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // a stalled result must hold
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // reset empties the pipeline
    `ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // a miss carries all-zero data
    `ASSERT_CLK(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "miss with non-zero data")

endmodule

bind ray_disk_intersect_uv rdi_checker u_rdi_checker (.*);

`default_nettype wire
